// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define B64D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define B64D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, constants and the character decode function of the base64 decoder.
package b64d_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    // Padding character.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Position of the closing character inside a group of four.
    localparam logic [1:0] POS_LAST = 2'd3;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // One decoded group or one error, as handed from front to back.
    typedef struct packed {
        logic [2:0][7:0] bytes;   // byte k of the group at index k
        logic [1:0]      status;  // ST_OK, or the error code
        logic [1:0]      count;   // number of results, 1 to 3
        logic            done;    // the last result ends the message
    } t_rec;

    // Maps a character to {valid, sextet}; the sextet is zero when not valid.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            return {1'b1, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h47;
            return {1'b1, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c + 8'h04;
            return {1'b1, d[5:0]};
        end else if (c == 8'h2B) begin
            return {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

endpackage

// ===== hw/rtl/b64d_queue.sv =====
// Short register queue of decoded group records between the front and back parts.
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output b64d_pkg::t_rec o_rec,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Pointer wrap and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// ===== hw/rtl/b64d_front.sv =====
// Front part: accepts characters, checks them, gathers groups and queues records.
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_symbol,
    input  logic           i_message_end,
    input  logic           i_full,
    output logic           o_push,
    output b64d_pkg::t_rec o_rec
);

    logic [1:0]  r_pos;
    logic [17:0] r_sext;
    logic        r_pad;
    logic        r_disc;
    logic [1:0]  n_pos;
    logic [17:0] n_sext;
    logic        n_pad;
    logic        n_disc;

    logic        accept;
    logic [6:0]  decoded;
    logic        is_valid;
    logic [5:0]  sv;
    logic        is_pad;
    logic        bad;
    logic [1:0]  cnt;

    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign decoded  = b64d_pkg::sextet_of(i_symbol);
    assign is_valid = decoded[6];
    assign sv       = decoded[5:0];
    assign is_pad   = (i_symbol == b64d_pkg::PAD_CHAR);
    assign cnt      = r_pad ? 2'd1 : (is_pad ? 2'd2 : 2'd3);

    // Character check by position; padding is legal only in the third and fourth.
    always_comb begin
        if (r_pos == 2'd0 || r_pos == 2'd1) begin
            bad = !is_valid;
        end else if (r_pos == 2'd2) begin
            bad = !is_valid && !is_pad;
        end else begin
            bad = r_pad ? !is_pad : (!is_valid && !is_pad);
        end
    end

    // Group state update and record build.
    always_comb begin
        n_pos        = r_pos;
        n_sext       = r_sext;
        n_pad        = r_pad;
        n_disc       = r_disc;
        o_push       = 1'b0;
        o_rec.bytes  = '0;
        o_rec.status = b64d_pkg::ST_OK;
        o_rec.count  = 2'd1;
        o_rec.done   = 1'b1;
        if (accept) begin
            if (r_disc) begin
                // Drop the rest of a failed message.
                if (i_message_end) begin
                    n_disc = 1'b0;
                    n_pos  = '0;
                    n_sext = '0;
                    n_pad  = 1'b0;
                end
            end else if (bad) begin
                o_push       = 1'b1;
                o_rec.status = b64d_pkg::ST_BAD_CHAR;
                n_pos        = '0;
                n_sext       = '0;
                n_pad        = 1'b0;
                n_disc       = !i_message_end;
            end else if (r_pos != b64d_pkg::POS_LAST) begin
                n_sext = {r_sext[11:0], sv};
                n_pad  = r_pad || is_pad;
                n_pos  = r_pos + 2'd1;
                // A message that ends inside a group is too short.
                if (i_message_end) begin
                    o_push       = 1'b1;
                    o_rec.status = b64d_pkg::ST_BAD_LEN;
                    n_pos        = '0;
                    n_sext       = '0;
                    n_pad        = 1'b0;
                    n_disc       = 1'b0;
                end
            end else if (cnt != 2'd3 && !i_message_end) begin
                // A padded group that is not the last one of the message.
                o_push       = 1'b1;
                o_rec.status = b64d_pkg::ST_BAD_CHAR;
                n_pos        = '0;
                n_sext       = '0;
                n_pad        = 1'b0;
                n_disc       = 1'b1;
            end else begin
                o_push          = 1'b1;
                o_rec.bytes[0]  = {r_sext[17:12], r_sext[11:10]};
                o_rec.bytes[1]  = {r_sext[9:6], r_sext[5:2]};
                o_rec.bytes[2]  = {r_sext[1:0], sv};
                o_rec.count     = cnt;
                o_rec.done      = i_message_end;
                n_pos           = '0;
                n_sext          = '0;
                n_pad           = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sext <= '0;
            r_pad  <= 1'b0;
            r_disc <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_sext <= n_sext;
            r_pad  <= n_pad;
            r_disc <= n_disc;
        end
    end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// Back part: takes queued records and sends their results one per cycle while the output is ready.
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  b64d_pkg::t_rec i_rec,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data_byte,
    output logic [1:0]     o_status,
    output logic           o_run_last,
    output logic           o_message_done
);

    logic           r_valid;
    logic [1:0]     r_idx;
    b64d_pkg::t_rec r_rec;
    logic           n_valid;
    logic [1:0]     n_idx;
    logic           last;

    assign last  = ((r_idx + 2'd1) == r_rec.count);
    assign o_pop = (!r_valid || (i_ready && last)) && !i_empty;

    // Walk through the results of the current record.
    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_pop) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (r_valid && i_ready) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Record payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    // Result fields from the held record.
    always_comb begin
        unique case (r_idx)
            2'd0:    o_data_byte = r_rec.bytes[0];
            2'd1:    o_data_byte = r_rec.bytes[1];
            2'd2:    o_data_byte = r_rec.bytes[2];
            default: o_data_byte = 8'h00;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_status       = r_rec.status;
    assign o_run_last     = last;
    assign o_message_done = last && r_rec.done;

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// Streaming base64 decoder top level: front checker, record queue and result sender.
// Throughput: one character request per cycle while the queue has room; one result per cycle while output is ready.
// A closed group or error is written into the record queue, then taken into the result sender's held record.
// The input stalls only while the record queue between front and back is full.
// Reset (synchronous, active low) clears group state, the queue and the output valid.
module base64_stream_decoder #(
    parameter int P_QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] symbol
    input  logic       i_s_axis_tlast,   // message_end
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] data_byte
    output logic [2:0] o_m_axis_tuser,   // [1:0] status, [2] run_last
    output logic       o_m_axis_tlast    // message_done
);

    b64d_pkg::t_rec push_rec;
    b64d_pkg::t_rec head_rec;
    logic           push;
    logic           pop;
    logic           full;
    logic           empty;
    logic [1:0]     status;
    logic           run_last;

    // Character intake and group assembly.
    b64d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_symbol      (i_s_axis_tdata),
        .i_message_end (i_s_axis_tlast),
        .i_full        (full),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    // Decouples the two parts.
    b64d_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_empty (empty)
    );

    // Result sender.
    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (head_rec),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_data_byte    (o_m_axis_tdata),
        .o_status       (status),
        .o_run_last     (run_last),
        .o_message_done (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {run_last, status};

endmodule

// ===== hw/rtl/b64d_checker.sv =====
// Port-level checker of the base64 decoder and its bind to the top level.
`include "assert_macros.svh"

module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [2:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // An error result carries a zero byte and closes both the run and the message.
    `B64D_ASSERT(a_err_shape, o_m_axis_tvalid && o_m_axis_tuser[1:0] != b64d_pkg::ST_OK |-> o_m_axis_tdata == 8'h00 && o_m_axis_tuser[2] && o_m_axis_tlast, "error result has wrong shape")

    // The status never takes the unused code.
    `B64D_ASSERT(a_status_code, o_m_axis_tvalid |-> o_m_axis_tuser[1:0] == b64d_pkg::ST_OK || o_m_axis_tuser[1:0] == b64d_pkg::ST_BAD_CHAR || o_m_axis_tuser[1:0] == b64d_pkg::ST_BAD_LEN, "status out of range")

    // A message ends only on the last result of a request.
    `B64D_ASSERT(a_done_on_last, o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser[2], "message end without run end")

    // A stalled result holds.
    `B64D_ASSERT(a_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled result changed")

    // No result right after a reset cycle.
    `B64D_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
